// ===== rtl/timed_slew_rate_limiter_unit_assert.svh =====
// assertion macros for the timed slew-rate limiter checker
// no dependencies; included by the checker file only
`ifndef TIMED_SLEW_RATE_LIMITER_UNIT_ASSERT_SVH
`define TIMED_SLEW_RATE_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication
`define TSRL_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tsrl check failed");

// next-cycle implication
`define TSRL_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tsrl check failed");

`endif

// ===== rtl/tsrl_pkg.sv =====
// shared types and constants for the timed slew-rate limiter
// no dependencies; used by every module of the block
`default_nettype none

package tsrl_pkg;

  // field widths
  localparam int TIME_W = 63;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 32;
  localparam int AMT_W  = 31;

  // default width of the internal current value
  localparam int VALUE_BITS_DEF = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_AMOUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_TIME    = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] UPDATE_PERIOD_RST = 32'd1000000;
  localparam logic [AMT_W-1:0] SLOPE_AMOUNT_RST  = 31'd65536;
  localparam logic [CFG_W-1:0] SLOPE_TIME_RST    = 32'd1000000;

  // largest timestamp
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // request payload
  typedef struct packed {
    logic [TIME_W-1:0]        now_time;
    logic signed [DATA_W-1:0] target_value;
  } in_t;

  // result payload
  typedef struct packed {
    logic signed [DATA_W-1:0] smoothed_value;
    logic                     settled;
    logic [TIME_W-1:0]        next_update_at;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/tsrl_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on tsrl_pkg for the operand widths
`default_nettype none

module tsrl_mul (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic [tsrl_pkg::CFG_W-1:0]                a_i,
  input  wire logic [tsrl_pkg::AMT_W-1:0]                b_i,
  output logic                                           busy_o,
  output logic [tsrl_pkg::CFG_W+tsrl_pkg::AMT_W-1:0]     prod_o
);
  import tsrl_pkg::*;

  localparam int PROD_W = CFG_W + AMT_W;
  localparam int CNT_W  = $clog2(AMT_W + 1);

  logic [CFG_W-1:0]  a_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CFG_W:0]    sum;

  // add the multiplicand into the high half, then shift right
  always_comb begin
    sum    = {1'b0, prod_q[PROD_W-1:AMT_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {sum, prod_q[AMT_W-1:1]};
  end

  // step counter
  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(AMT_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // operand and product shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{CFG_W{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      prod_q <= prod_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/tsrl_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tsrl_pkg for the dividend and divisor widths
`default_nettype none

module tsrl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [tsrl_pkg::TIME_W-1:0]   dividend_i,
  input  wire logic [tsrl_pkg::CFG_W-1:0]    divisor_i,
  output logic                               busy_o,
  output logic [tsrl_pkg::TIME_W-1:0]        quo_o,
  output logic [tsrl_pkg::CFG_W-1:0]         rem_o
);
  import tsrl_pkg::*;

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [CFG_W-1:0]  den_q;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [TIME_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CFG_W:0]    shifted, trial;
  logic              fits;

  // bring in the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_q, quo_q[TIME_W-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = (shifted >= {1'b0, den_q});
    rem_d   = fits ? trial[CFG_W-1:0] : shifted[CFG_W-1:0];
    quo_d   = {quo_q[TIME_W-2:0], fits};
  end

  // step counter
  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CNT_W'(TIME_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // partial remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/timed_slew_rate_limiter_unit.sv =====
// timed slew-rate limiter: sequencer, state and output register
// depends on tsrl_pkg, tsrl_mul and tsrl_div
//
//   channel   direction  payload              handshake
//   in        request    tsrl_pkg::in_t       in_valid_i / in_stall_o
//   out       result     tsrl_pkg::out_t      out_valid_o / out_stall_i
//   cfg       write      cfg_idx_i/cfg_data_i cfg_we_i
//
// an item goes from acceptance to its result through two 63-step passes
// through the bit-serial divider (the 31-step multiply runs alongside the
// first pass); the next item is taken in the cycle after that.
// reset clears the state to zero and the registers to their defaults.
// a stalled result is held in the output register; a new item may be taken
// meanwhile, and its result waits until the register is free.
`default_nettype none

module timed_slew_rate_limiter_unit #(
  parameter int VALUE_BITS = tsrl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire tsrl_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output tsrl_pkg::out_t                         out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tsrl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tsrl_pkg::CFG_W-1:0]        cfg_data_i
);
  import tsrl_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_CLAMP = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_RUN1  = 3'd4;
  localparam logic [2:0] ST_RUN2  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [CFG_W-1:0] upd_period_q;
  logic [AMT_W-1:0] slope_amt_q;
  logic [CFG_W-1:0] slope_time_q;
  logic [CFG_W-1:0] period_eff, stime_eff;

  // block state
  logic [VALUE_BITS-1:0] cur_q, cur_d;
  logic [TIME_W-1:0]     last_q;
  logic [TIME_W-1:0]     next_q, next_d;

  // per-item working registers
  in_t                   req_q;
  logic [TIME_W:0]       dlast_q;
  logic [TIME_W:0]       dnext_q;
  logic [CFG_W-1:0]      elapsed_q;
  logic [VALUE_BITS-1:0] tgt_q;
  logic [VALUE_BITS-1:0] dist_q;
  logic                  below_q;
  logic [TIME_W-1:0]     base_q;

  // output register
  out_t out_q;
  logic out_valid_q;

  // arithmetic units
  logic                    mul_start, mul_busy;
  logic [CFG_W+AMT_W-1:0]  mul_prod;
  logic                    div_start, div_busy;
  logic [TIME_W-1:0]       div_dividend, div_quo;
  logic [CFG_W-1:0]        div_divisor, div_rem;

  // combinational helpers
  logic                  in_acc, out_load, units_idle, adv;
  logic [VALUE_BITS-1:0] tgt_ext;
  logic [CFG_W-1:0]      elapsed_d;
  logic                  snap;
  logic [VALUE_BITS-1:0] step_val;
  logic [TIME_W:0]       nxt_sum;

  assign period_eff = (upd_period_q == '0) ? CFG_W'(1) : upd_period_q;
  assign stime_eff  = (slope_time_q == '0) ? CFG_W'(1) : slope_time_q;

  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign units_idle = !div_busy && !mul_busy;
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign adv        = !dnext_q[TIME_W];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_period_q <= UPDATE_PERIOD_RST;
      slope_amt_q  <= SLOPE_AMOUNT_RST;
      slope_time_q <= SLOPE_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UPDATE_PERIOD: upd_period_q <= cfg_data_i;
        CFG_SLOPE_AMOUNT:  slope_amt_q  <= cfg_data_i[AMT_W-1:0];
        CFG_SLOPE_TIME:    slope_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_START;
      ST_START: state_d = ST_RUN1;
      ST_RUN1:  if (units_idle) state_d = ST_RUN2;
      ST_RUN2:  if (!div_busy) state_d = ST_FIN;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // elapsed time clamped to zero and to the period
  always_comb begin
    if (dlast_q[TIME_W]) begin
      elapsed_d = '0;
    end else if (dlast_q[TIME_W-1:0] > TIME_W'(period_eff)) begin
      elapsed_d = period_eff;
    end else begin
      elapsed_d = dlast_q[CFG_W-1:0];
    end
  end

  assign tgt_ext = VALUE_BITS'(req_q.target_value);

  // first pass: (now - next) / period for the schedule, product alongside
  // second pass: elapsed * slope_amount / slope_time for the allowed change
  assign mul_start    = (state_q == ST_START);
  assign div_start    = (state_q == ST_START) || ((state_q == ST_RUN1) && units_idle);
  assign div_dividend = (state_q == ST_START) ? dnext_q[TIME_W-1:0] : TIME_W'(mul_prod);
  assign div_divisor  = (state_q == ST_START) ? period_eff : stime_eff;

  tsrl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (elapsed_q),
    .b_i     (slope_amt_q),
    .busy_o  (mul_busy),
    .prod_o  (mul_prod)
  );

  tsrl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // working registers along the sequence
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_DIFF) begin
      dlast_q <= {1'b0, req_q.now_time} - {1'b0, last_q};
      dnext_q <= {1'b0, req_q.now_time} - {1'b0, next_q};
      tgt_q   <= tgt_ext;
    end
    if (state_q == ST_CLAMP) begin
      elapsed_q <= elapsed_d;
      below_q   <= ($signed(tgt_q) < $signed(cur_q));
      dist_q    <= ($signed(tgt_q) < $signed(cur_q)) ? (cur_q - tgt_q) : (tgt_q - cur_q);
    end
    if ((state_q == ST_RUN1) && units_idle) begin
      base_q <= req_q.now_time - TIME_W'(div_rem);
    end
  end

  // limited step and schedule advance
  always_comb begin
    snap     = (64'(div_quo) > 64'(dist_q));
    step_val = below_q ? (cur_q - VALUE_BITS'(div_quo)) : (cur_q + VALUE_BITS'(div_quo));
    cur_d    = snap ? tgt_q : step_val;
    nxt_sum  = {1'b0, base_q} + (TIME_W + 1)'(period_eff);
    next_d   = next_q;
    if (adv) begin
      next_d = nxt_sum[TIME_W] ? TIME_MAX : nxt_sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      last_q <= '0;
      next_q <= '0;
    end else if (out_load) begin
      cur_q  <= cur_d;
      last_q <= next_q;
      next_q <= next_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.smoothed_value <= DATA_W'(cur_d);
      out_q.settled        <= snap;
      out_q.next_update_at <= next_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/tsrl_checker.sv =====
// port-level checks for the timed slew-rate limiter, bound to the top level
// depends on tsrl_pkg and timed_slew_rate_limiter_unit_assert.svh
`default_nettype none

`include "timed_slew_rate_limiter_unit_assert.svh"

module tsrl_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire tsrl_pkg::out_t out_data_o
);

  // a stalled result stays offered
  `TSRL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // a stalled result keeps its payload
  `TSRL_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // an accepted request keeps the block busy in the next cycle
  `TSRL_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only appears while a request is being worked on
  `TSRL_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind timed_slew_rate_limiter_unit tsrl_checker u_tsrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking bench for timed_slew_rate_limiter_unit: directed and random updates
// depends on tsrl_pkg and the timed_slew_rate_limiter_unit rtl
`timescale 1ns / 1ps

module tb_top;
  import tsrl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_UPDATE_PERIOD;
  logic [CFG_W-1:0] cfg_data_i = '0;

  timed_slew_rate_limiter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // register copies used by the predictor
  logic [CFG_W-1:0] period_reg = UPDATE_PERIOD_RST;
  logic [AMT_W-1:0] amount_reg = SLOPE_AMOUNT_RST;
  logic [CFG_W-1:0] slope_time_reg = SLOPE_TIME_RST;

  // predicted limiter state
  logic [DATA_W-1:0] cur_value = '0;
  logic [TIME_W-1:0] last_time = '0;
  logic [TIME_W-1:0] next_time = '0;

  in_t queued_updates[$];
  out_t predicted_updates[$];

  int accepted_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int settled_count = 0;
  int settings_count = 1;

  // stimulus generator state
  logic [63:0] gen_now = '0;
  logic [DATA_W-1:0] last_target = '0;

  // limited step toward the target plus schedule advance
  function automatic out_t predict_update(in_t req);
    logic [63:0] period, stime, elapsed, allowed, gap, adv, nxt;
    logic [DATA_W-1:0] tgt;
    logic below;
    out_t res;
    period = (period_reg == 0) ? 64'd1 : {32'b0, period_reg};
    stime = (slope_time_reg == 0) ? 64'd1 : {32'b0, slope_time_reg};
    elapsed = (req.now_time >= last_time) ? {1'b0, req.now_time - last_time} : 64'd0;
    if (elapsed > period) elapsed = period;
    allowed = (elapsed * {33'b0, amount_reg}) / stime;
    tgt = req.target_value;
    below = $signed(tgt) < $signed(cur_value);
    gap = below ? {32'b0, cur_value - tgt} : {32'b0, tgt - cur_value};
    res.settled = 1'b0;
    if (gap < allowed) begin
      cur_value = tgt;
      res.settled = 1'b1;
    end else if (below) begin
      cur_value = cur_value - allowed[DATA_W-1:0];
    end else begin
      cur_value = cur_value + allowed[DATA_W-1:0];
    end
    // schedule: whole periods past now, held at the largest timestamp
    last_time = next_time;
    if (next_time <= req.now_time) begin
      adv = ({1'b0, req.now_time - next_time} / period + 64'd1) * period;
      nxt = {1'b0, next_time} + adv;
      next_time = (nxt > {1'b0, TIME_MAX}) ? TIME_MAX : nxt[TIME_W-1:0];
    end
    res.smoothed_value = cur_value;
    res.next_update_at = next_time;
    return res;
  endfunction

  // mostly well-paced timestamps, some repeats, backward steps and jumps
  function automatic in_t gen_sched_request();
    in_t req;
    logic [63:0] span, step, now;
    int pick;
    span = ((period_reg == 0) ? 64'd1 : {32'b0, period_reg}) * 2 + 1;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      step = {$urandom, $urandom} % span;
      gen_now = gen_now + step;
      now = gen_now;
    end else if (pick < 78) begin
      now = gen_now;
    end else if (pick < 86) begin
      step = {$urandom, $urandom} % span;
      now = (gen_now > step) ? gen_now - step : 64'd0;
    end else if (pick < 93) begin
      gen_now = gen_now + ({$urandom, $urandom} & 64'hF_FFFF_FFFF);
      now = gen_now;
    end else begin
      gen_now = gen_now + ((period_reg == 0) ? 64'd1 : {32'b0, period_reg});
      now = gen_now;
    end
    pick = $urandom_range(0, 9);
    if (pick >= 7) last_target = $urandom;
    else if (pick >= 4) last_target = 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    req.now_time = now[TIME_W-1:0];
    req.target_value = last_target;
    return req;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predicted_updates.push_back(predict_update(in_data_i));
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (queued_updates.size() != 0 &&
            ((accepted_count >= 700 && accepted_count < 1000) ||
             $urandom_range(0, 99) >= 9)) begin
          in_valid_i <= 1'b1;
          in_data_i <= queued_updates.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_updates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: value %h settled %0b next %h",
                     out_data_o.smoothed_value, out_data_o.settled,
                     out_data_o.next_update_at);
        end else begin
          out_t want;
          want = predicted_updates.pop_front();
          if (want.settled) settled_count++;
          if (out_data_o.smoothed_value !== want.smoothed_value ||
              out_data_o.settled !== want.settled ||
              out_data_o.next_update_at !== want.next_update_at) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch at result %0d: exp value %h settled %0b next %h",
                       checked_count, want.smoothed_value, want.settled,
                       want.next_update_at);
              $display("  got value %h settled %0b next %h",
                       out_data_o.smoothed_value, out_data_o.settled,
                       out_data_o.next_update_at);
            end
          end
        end
        checked_count++;
      end
      out_stall_i <= !(checked_count >= 700 && checked_count < 1000) &&
                     ($urandom_range(0, 99) < 9);
    end
  end

  // register write, mirrored into the predictor copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_UPDATE_PERIOD: period_reg = val;
      CFG_SLOPE_AMOUNT:  amount_reg = val[AMT_W-1:0];
      CFG_SLOPE_TIME:    slope_time_reg = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] amt,
                                input logic [CFG_W-1:0] stm);
    write_reg(CFG_UPDATE_PERIOD, per);
    write_reg(CFG_SLOPE_AMOUNT, amt);
    write_reg(CFG_SLOPE_TIME, stm);
    settings_count++;
    @(negedge clk_i);
  endtask

  // random register set, zero values now and then
  task automatic random_settings();
    logic [CFG_W-1:0] per, amt, stm;
    case ($urandom_range(0, 4))
      0: per = $urandom_range(1, 1000);
      1: per = $urandom_range(1, 1 << 20);
      2: per = $urandom;
      3: per = 32'hFFFF_FFFF;
      default: per = '0;
    endcase
    case ($urandom_range(0, 3))
      0: amt = $urandom_range(0, 1 << 17);
      1: amt = $urandom;
      2: amt = {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
      default: amt = {1'($urandom_range(0, 1)), 31'd0};
    endcase
    case ($urandom_range(0, 4))
      0: stm = $urandom_range(1, 1000);
      1: stm = $urandom_range(1, 1 << 20);
      2: stm = $urandom;
      3: stm = 32'hFFFF_FFFF;
      default: stm = '0;
    endcase
    apply_settings(per, amt, stm);
  endtask

  task automatic push_req(input logic [63:0] now, input logic [DATA_W-1:0] tgt);
    in_t req;
    req.now_time = now[TIME_W-1:0];
    req.target_value = tgt;
    queued_updates.push_back(req);
  endtask

  // wait until every request is in and every result is out
  task automatic drain();
    do @(negedge clk_i);
    while (queued_updates.size() != 0 || in_valid_i || predicted_updates.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_sched_phase(input int n);
    gen_now = gen_now + (64'd1 << 33);
    @(negedge clk_i);
    repeat (n) queued_updates.push_back(gen_sched_request());
    drain();
  endtask

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // default registers: at target with no allowed change, extremes, time going back
    push_req(64'd0, 32'd0);
    push_req(64'd250000, 32'h7FFF_FFFF);
    push_req(64'd1000000, 32'h8000_0000);
    push_req(64'd1500000, 32'hFFFF_FFFF);
    push_req(64'd900000, 32'd0);
    push_req(64'd3000000, 32'd0);
    push_req(64'd3000000, 32'd0);
    push_req(64'd10000000, 32'h0001_0000);
    push_req(64'd12000000, 32'h0000_8000);
    drain();

    // zero period and zero slope time act as one, widest slope amount
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'd0);
    push_req(64'd20000000, 32'h7FFF_FFFF);
    push_req(64'd20000001, 32'h8000_0000);
    push_req(64'd20000002, 32'd0);
    push_req(64'd20000002, 32'h1234_5678);
    push_req(64'd20000007, 32'hFFFF_0000);
    drain();

    // unit steps
    apply_settings(32'd1, 32'd1, 32'd1);
    push_req(64'd30000000, 32'h0000_0003);
    push_req(64'd30000001, 32'h0000_0003);
    push_req(64'd30000002, 32'hFFFF_FFFD);
    push_req(64'd30000003, 32'hFFFF_FFFD);
    drain();

    // widest period and slope time with no slope
    apply_settings(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    push_req(64'd40000000, 32'h7FFF_FFFF);
    push_req(64'd40000005, 32'h8000_0000);
    push_req(64'd5040000000, 32'd0);
    drain();

    // random updates over several register settings
    gen_now = 64'd1 << 34;
    apply_settings(UPDATE_PERIOD_RST, {1'b0, SLOPE_AMOUNT_RST}, SLOPE_TIME_RST);
    run_sched_phase(200);
    for (int ph = 0; ph < 6; ph++) begin
      random_settings();
      run_sched_phase(200);
    end

    // full-range timestamps, then the schedule runs into the largest timestamp
    apply_settings(32'h7FFF_FFFF, $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 16));
    repeat (90) push_req({$urandom, $urandom}, $urandom);
    push_req({1'b0, TIME_MAX} - 64'd3, $urandom);
    push_req({1'b0, TIME_MAX} - 64'd1, $urandom);
    push_req({1'b0, TIME_MAX}, $urandom);
    push_req({1'b0, TIME_MAX}, $urandom);
    drain();
    repeat (150) @(negedge clk_i);

    if (predicted_updates.size() != 0) begin
      mismatch_count += predicted_updates.size();
      $display("%0d predicted results never arrived", predicted_updates.size());
    end
    $display("covered %0d requests under %0d register settings", accepted_count, settings_count);
    $display("checked %0d results, %0d of them settled, %0d mismatches",
             checked_count, settled_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("timed_slew_rate_limiter_unit regression: pass");
    end else begin
      $display("timed_slew_rate_limiter_unit regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("timed_slew_rate_limiter_unit regression: fail");
    $finish;
  end

endmodule
